// ===== rtl/prw_pkg.sv =====
// Shared constants and types for the particle weight resampler.
package prw_pkg;

  localparam int DEF_MAX_PARTICLES = 64;
  localparam int WEIGHT_W = 16;
  localparam int CONF_W = 16;
  localparam int QUOT_W = CONF_W + 1;
  localparam int QBIT_W = 5;
  localparam logic [CONF_W-1:0] THRESHOLD_RESET = 16'h8000;
  localparam logic [CONF_W-1:0] CONF_MAX = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_CLOSE,
    ST_TT_MUL,
    ST_DEN_MUL,
    ST_DEN_CAP,
    ST_DIV,
    ST_DIV_END,
    ST_UT_MUL,
    ST_UT_CAP,
    ST_NW_MUL,
    ST_NW_ACC,
    ST_CMP,
    ST_EMIT_ID
  } state_t;

  typedef enum logic [2:0] {
    OP_WW,
    OP_TT,
    OP_NS,
    OP_UT,
    OP_NW
  } mul_op_t;

endpackage

// ===== rtl/prw_mul.sv =====
// Shared multiplier with a registered product.
module prw_mul #(
  parameter int A_W = 22,
  parameter int B_W = 38
) (
  input  logic               clk,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
  end

endmodule

// ===== rtl/prw_wstore.sv =====
// Weight store: one write port, one registered read port.
module prw_wstore #(
  parameter int DEPTH = 64,
  parameter int ADDR_W = 6
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [prw_pkg::WEIGHT_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]            rd_addr,
  output logic [prw_pkg::WEIGHT_W-1:0] rd_data
);

  logic [prw_pkg::WEIGHT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/particle_weight_resampler_core.sv =====
// Top level of the particle weight resampler: sequencer and datapath.
// Each weight is accepted, squared on the shared multiplier and then
// accumulated. The item marked last then closes the set: products and set-up,
// a 17-step restoring division for confidence, a decision step, and the walk.
// With no resampling (or all weights zero) N identity results follow, one a
// cycle. With resampling, the start product and the first weight are loaded;
// then each output slot is issued from a compare step, and every advance of the
// source pointer runs through a compare, a store read and multiply, and an add.
// busy is high while each accepted weight is squared and accumulated, and from
// the last weight until the last result is issued; results come as one-cycle
// strobes on result_valid and cannot be held off. cfg_ready is always high.
module particle_weight_resampler_core #(
  parameter int MAX_PARTICLES = prw_pkg::DEF_MAX_PARTICLES,
  localparam int IDX_W = $clog2(MAX_PARTICLES)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [prw_pkg::WEIGHT_W-1:0] weight,
  input  logic [prw_pkg::WEIGHT_W-1:0] start_offset,
  input  logic                         last_weight,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [prw_pkg::CONF_W-1:0]   cfg_data,
  output logic                         result_valid,
  output logic [IDX_W-1:0]             source_index,
  output logic                         did_resample,
  output logic [prw_pkg::CONF_W-1:0]   confidence,
  output logic                         last_index
);

  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam int TOT_W = prw_pkg::WEIGHT_W + IDX_W;
  localparam int SQ_W = 2 * prw_pkg::WEIGHT_W + IDX_W;
  localparam int PROD_W = TOT_W + SQ_W;
  localparam int DV_W = CNT_W + SQ_W + 16;
  localparam int LHS_W = CNT_W + 16 + TOT_W;
  localparam int NC_W = CNT_W + TOT_W;

  prw_pkg::state_t state, state_next;
  prw_pkg::mul_op_t mul_op;

  logic [prw_pkg::CONF_W-1:0]   threshold;
  logic [CNT_W-1:0]             count;
  logic [TOT_W-1:0]             total;
  logic [SQ_W-1:0]              sqsum;
  logic [prw_pkg::WEIGHT_W-1:0] w_r;
  logic [prw_pkg::WEIGHT_W-1:0] u_r;
  logic                         last_r;
  logic                         stored;
  logic [DV_W-1:0]              rem;
  logic [DV_W-1:0]              dsh;
  logic [prw_pkg::QUOT_W-1:0]   quot;
  logic [prw_pkg::QBIT_W-1:0]   qbit;
  logic [LHS_W-1:0]             lhs;
  logic [NC_W-1:0]              ncum;
  logic [IDX_W-1:0]             idx;
  logic [IDX_W-1:0]             slot;
  logic                         resample;
  logic [prw_pkg::CONF_W-1:0]   conf;

  logic [TOT_W-1:0]             mul_a;
  logic [SQ_W-1:0]              mul_b;
  logic [PROD_W-1:0]            prod;
  logic                         wr_en;
  logic [IDX_W-1:0]             rd_addr;
  logic [prw_pkg::WEIGHT_W-1:0] rd_data;
  logic                         accept;
  logic                         advance;
  logic                         slot_last;
  logic [prw_pkg::CONF_W-1:0]   conf_sat;

  assign busy      = (state != prw_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign wr_en     = accept && (count < CNT_W'(MAX_PARTICLES));
  assign advance   = ((CNT_W'(idx) + 1'b1) < count) && (lhs > {ncum, 16'h0000});
  assign slot_last = (CNT_W'(slot) == (count - 1'b1));
  assign conf_sat  = quot[prw_pkg::QUOT_W-1] ? prw_pkg::CONF_MAX
                                             : quot[prw_pkg::CONF_W-1:0];

  prw_wstore #(
    .DEPTH  (MAX_PARTICLES),
    .ADDR_W (IDX_W)
  ) u_wstore (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data (weight),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  prw_mul #(
    .A_W (TOT_W),
    .B_W (SQ_W)
  ) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_comb begin
    case (mul_op)
      prw_pkg::OP_WW: begin
        mul_a = TOT_W'(w_r);
        mul_b = SQ_W'(w_r);
      end
      prw_pkg::OP_TT: begin
        mul_a = total;
        mul_b = SQ_W'(total);
      end
      prw_pkg::OP_NS: begin
        mul_a = TOT_W'(count);
        mul_b = sqsum;
      end
      prw_pkg::OP_UT: begin
        mul_a = total;
        mul_b = SQ_W'(u_r);
      end
      default: begin
        mul_a = TOT_W'(count);
        mul_b = SQ_W'(rd_data);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_op     = prw_pkg::OP_NW;
    rd_addr    = idx;
    unique case (state)
      prw_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = prw_pkg::ST_SQ_MUL;
        end
      end
      prw_pkg::ST_SQ_MUL: begin
        mul_op     = prw_pkg::OP_WW;
        state_next = prw_pkg::ST_SQ_ACC;
      end
      prw_pkg::ST_SQ_ACC: begin
        state_next = last_r ? prw_pkg::ST_CLOSE : prw_pkg::ST_IDLE;
      end
      prw_pkg::ST_CLOSE: begin
        state_next = (total == '0) ? prw_pkg::ST_EMIT_ID : prw_pkg::ST_TT_MUL;
      end
      prw_pkg::ST_TT_MUL: begin
        mul_op     = prw_pkg::OP_TT;
        state_next = prw_pkg::ST_DEN_MUL;
      end
      prw_pkg::ST_DEN_MUL: begin
        mul_op     = prw_pkg::OP_NS;
        state_next = prw_pkg::ST_DEN_CAP;
      end
      prw_pkg::ST_DEN_CAP: begin
        state_next = prw_pkg::ST_DIV;
      end
      prw_pkg::ST_DIV: begin
        if (qbit == '0) begin
          state_next = prw_pkg::ST_DIV_END;
        end
      end
      prw_pkg::ST_DIV_END: begin
        state_next = (conf_sat < threshold) ? prw_pkg::ST_UT_MUL : prw_pkg::ST_EMIT_ID;
      end
      prw_pkg::ST_UT_MUL: begin
        mul_op     = prw_pkg::OP_UT;
        rd_addr    = '0;
        state_next = prw_pkg::ST_UT_CAP;
      end
      prw_pkg::ST_UT_CAP: begin
        mul_op     = prw_pkg::OP_NW;
        state_next = prw_pkg::ST_NW_ACC;
      end
      prw_pkg::ST_NW_MUL: begin
        mul_op     = prw_pkg::OP_NW;
        state_next = prw_pkg::ST_NW_ACC;
      end
      prw_pkg::ST_NW_ACC: begin
        state_next = prw_pkg::ST_CMP;
      end
      prw_pkg::ST_CMP: begin
        if (advance) begin
          rd_addr    = idx + 1'b1;
          state_next = prw_pkg::ST_NW_MUL;
        end else if (slot_last) begin
          state_next = prw_pkg::ST_IDLE;
        end
      end
      prw_pkg::ST_EMIT_ID: begin
        if (slot_last) begin
          state_next = prw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = prw_pkg::ST_IDLE;
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= prw_pkg::THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  // set totals; cleared once the run has issued its last result
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
      sqsum <= '0;
    end else if (wr_en) begin
      count <= count + 1'b1;
      total <= total + TOT_W'(weight);
    end else if (state == prw_pkg::ST_SQ_ACC && stored) begin
      sqsum <= sqsum + SQ_W'(prod);
    end else if (state_next == prw_pkg::ST_IDLE &&
                 (state == prw_pkg::ST_CMP || state == prw_pkg::ST_EMIT_ID)) begin
      count <= '0;
      total <= '0;
      sqsum <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == prw_pkg::ST_EMIT_ID) ||
                      (state == prw_pkg::ST_CMP && !advance);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      w_r    <= weight;
      u_r    <= start_offset;
      last_r <= last_weight;
      stored <= wr_en;
    end
    case (state)
      prw_pkg::ST_CLOSE: begin
        slot     <= '0;
        conf     <= prw_pkg::CONF_MAX;
        resample <= 1'b0;
      end
      prw_pkg::ST_DEN_MUL: begin
        rem <= DV_W'({prod, 16'h0000});
      end
      prw_pkg::ST_DEN_CAP: begin
        dsh  <= DV_W'({prod, 16'h0000});
        quot <= '0;
        qbit <= prw_pkg::QBIT_W'(prw_pkg::QUOT_W - 1);
      end
      prw_pkg::ST_DIV: begin
        if (dsh <= rem) begin
          rem  <= rem - dsh;
          quot <= quot | (prw_pkg::QUOT_W'(1) << qbit);
        end
        dsh  <= dsh >> 1;
        qbit <= qbit - 1'b1;
      end
      prw_pkg::ST_DIV_END: begin
        conf     <= conf_sat;
        resample <= (conf_sat < threshold);
      end
      prw_pkg::ST_UT_CAP: begin
        lhs  <= LHS_W'(prod);
        idx  <= '0;
        ncum <= '0;
      end
      prw_pkg::ST_NW_ACC: begin
        ncum <= ncum + NC_W'(prod);
      end
      prw_pkg::ST_CMP: begin
        if (advance) begin
          idx <= idx + 1'b1;
        end else begin
          source_index <= idx;
          did_resample <= resample;
          confidence   <= conf;
          last_index   <= slot_last;
          lhs          <= lhs + LHS_W'({total, 16'h0000});
          slot         <= slot + 1'b1;
        end
      end
      prw_pkg::ST_EMIT_ID: begin
        source_index <= slot;
        did_resample <= resample;
        confidence   <= conf;
        last_index   <= slot_last;
        slot         <= slot + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/prw_checker.sv =====
// Port-level checks for the resampler core, bound to the top level.
module prw_checker #(
  parameter int IDX_W = 6
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       result_valid,
  input logic [IDX_W-1:0]           source_index,
  input logic                       did_resample,
  input logic [prw_pkg::CONF_W-1:0] confidence,
  input logic                       last_index
);

  // every accepted beat raises busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // results only follow busy cycles
  a_result_in_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result outside a run");

  // back-to-back results of one run share confidence and mode
  a_run_stable: assert property (@(posedge clk) disable iff (rst)
    (result_valid && $past(result_valid) && !$past(last_index)) |->
      (confidence == $past(confidence) && did_resample == $past(did_resample)))
    else $error("confidence or mode changed within a run");

  // resampled source indices never go backwards
  a_index_order: assert property (@(posedge clk) disable iff (rst)
    (result_valid && did_resample && $past(result_valid) && $past(did_resample) &&
     !$past(last_index)) |-> (source_index >= $past(source_index)))
    else $error("resampled index went backwards");

endmodule

bind particle_weight_resampler_core prw_checker #(
  .IDX_W (IDX_W)
) u_prw_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .source_index (source_index),
  .did_resample (did_resample),
  .confidence   (confidence),
  .last_index   (last_index)
);
